// File: src/clipped_alpha_blit_unit_assert.svh
// ----------------------------------------------------------------------------
// clipped_alpha_blit_unit_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_BLIT_UNIT_ASSERT_SVH
`define CLIPPED_ALPHA_BLIT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cab assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cab assertion failed");

`endif

// File: src/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// types, register indexes and reset values of the clipped alpha blit unit
// ----------------------------------------------------------------------------
package cab_pkg;

	// default screen size
	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ORIGIN_X       = 3'd0,
		REG_ORIGIN_Y       = 3'd1,
		REG_RECT_W         = 3'd2,
		REG_RECT_H         = 3'd3,
		REG_SRC_BASE_INDEX = 3'd4,
		REG_SRC_STRIDE     = 3'd5,
		REG_TINT_ENABLE    = 3'd6,
		REG_TINT_RGB       = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [10:0] ORIGIN_RST = 11'd0;
	localparam logic [9:0]  RECT_RST   = 10'd1;
	localparam logic [21:0] BASE_RST   = 22'd0;
	localparam logic [12:0] STRIDE_RST = 13'd1;
	localparam logic [23:0] TINT_RST   = 24'd0;

	// one incoming pixel request
	typedef struct packed {
		logic [31:0] source_pixel;
		logic [31:0] dest_pixel;
	} pixel_t;

	// one result
	typedef struct packed {
		logic        write_enable;
		logic [18:0] screen_index;
		logic [21:0] source_index;
		logic [23:0] blended_pixel;
		logic        last;
	} result_t;

endpackage

// File: src/clipped_alpha_blit_unit.sv
// ----------------------------------------------------------------------------
// clipped_alpha_blit_unit
// alpha blends a rectangular source region over the framebuffer, with clipping
//
// pixel channel: one request per position of the region, in raster order,
//   carrying the source word and the framebuffer word at that position
// result channel: one result per request, in order: write enable (position on
//   screen), screen word index, source word index, blended BGR word and a
//   last flag on the final position of the region
// cfg port: single-cycle writes by register index, which the user makes only
//   while idle (unenforced); they apply from the next request, no region restart
// path: an accepted request loads the input register, then moves into the
//   result register once that register is not stalled
// throughput: one request per cycle unless the result side stalls; the blend,
//   clip test and index adds all sit between the input and result registers
// stall: while a result waits, the input register still takes one more
//   request; pixel_ready drops only when both registers are full
// reset: registers go to their reset values, the column, row and source row
//   offset counters clear, both stages empty
// ----------------------------------------------------------------------------
module clipped_alpha_blit_unit #(
	parameter int SCREEN_WIDTH  = cab_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = cab_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// pixel requests
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  cab_pkg::pixel_t                pixel,
	// results
	output logic                           result_valid,
	input  logic                           result_ready,
	output cab_pkg::result_t               result,
	// configuration writes
	input  logic                           cfg_write,
	input  logic [cab_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cab_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// screen size as compare operands (both at most 1023)
	localparam logic [10:0] SCR_W = 11'(SCREEN_WIDTH);
	localparam logic [10:0] SCR_H = 11'(SCREEN_HEIGHT);

	// blend one channel: (s*a + d*(255-a)) / 256
	function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		logic [15:0] sum;
		sum = 16'(s) * 16'(a) + 16'(d) * 16'(8'hFF - a);
		return sum[15:8];
	endfunction

	// configuration registers
	logic [10:0] origin_x_q;
	logic [10:0] origin_y_q;
	logic [9:0]  rect_w_q;
	logic [9:0]  rect_h_q;
	logic [21:0] src_base_q;
	logic [12:0] src_stride_q;
	logic        tint_enable_q;
	logic [23:0] tint_rgb_q;

	// region walk counters
	logic [9:0]  column_q;
	logic [9:0]  row_q;
	logic [21:0] row_offset_q;

	// input stage
	logic        valid_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [9:0]  column_s1;
	logic [9:0]  row_s1;
	logic [21:0] row_offset_s1;
	logic        last_s1;

	// result stage
	logic             valid_s2;
	cab_pkg::result_t res_s2;

	logic stall;
	logic accept;
	logic row_end;
	logic region_end;

	// datapath between the stages
	logic [11:0]      sx;
	logic [11:0]      sy;
	logic             on_screen;
	logic [19:0]      row_base;
	logic [19:0]      scr_sum;
	logic [23:0]      rgb;
	logic [7:0]       alpha;
	cab_pkg::result_t res_d;

	// handshake: result register holds while the receiver stalls, the input
	// register can still fill behind it
	assign stall       = valid_s2 && !result_ready;
	assign pixel_ready = !(valid_s1 && stall);
	assign accept      = pixel_valid && pixel_ready;

	assign result_valid = valid_s2;
	assign result       = res_s2;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= cab_pkg::ORIGIN_RST;
			origin_y_q    <= cab_pkg::ORIGIN_RST;
			rect_w_q      <= cab_pkg::RECT_RST;
			rect_h_q      <= cab_pkg::RECT_RST;
			src_base_q    <= cab_pkg::BASE_RST;
			src_stride_q  <= cab_pkg::STRIDE_RST;
			tint_enable_q <= 1'b0;
			tint_rgb_q    <= cab_pkg::TINT_RST;
		end else if (cfg_write) begin
			unique case (cab_pkg::cfg_reg_t'(cfg_index))
				cab_pkg::REG_ORIGIN_X:       origin_x_q    <= cfg_data[10:0];
				cab_pkg::REG_ORIGIN_Y:       origin_y_q    <= cfg_data[10:0];
				cab_pkg::REG_RECT_W:         rect_w_q      <= cfg_data[9:0];
				cab_pkg::REG_RECT_H:         rect_h_q      <= cfg_data[9:0];
				cab_pkg::REG_SRC_BASE_INDEX: src_base_q    <= cfg_data[21:0];
				cab_pkg::REG_SRC_STRIDE:     src_stride_q  <= cfg_data[12:0];
				cab_pkg::REG_TINT_ENABLE:    tint_enable_q <= cfg_data[0];
				cab_pkg::REG_TINT_RGB:       tint_rgb_q    <= cfg_data[23:0];
			endcase
		end
	end

	// end of row / end of region; a zero width or height acts as one, and a
	// counter already past the edge also ends the row or region
	assign row_end    = ({1'b0, column_q} + 11'd1) >= {1'b0, rect_w_q};
	assign region_end = row_end && (({1'b0, row_q} + 11'd1) >= {1'b0, rect_h_q});

	// raster counters advance once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			row_offset_q <= '0;
		end else if (accept) begin
			priority if (region_end) begin
				column_q     <= '0;
				row_q        <= '0;
				row_offset_q <= '0;
			end else if (row_end) begin
				column_q     <= '0;
				row_q        <= row_q + 10'd1;
				row_offset_q <= row_offset_q + 22'(src_stride_q);
			end else begin
				column_q <= column_q + 10'd1;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (!stall) begin
				valid_s1 <= 1'b0;
			end
			if (!stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register payload, with a snapshot of the position
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1        <= pixel.source_pixel;
			dst_s1        <= pixel.dest_pixel;
			column_s1     <= column_q;
			row_s1        <= row_q;
			row_offset_s1 <= row_offset_q;
			last_s1       <= region_end;
		end
	end

	// clip, index and blend
	always_comb begin
		// screen position, signed 12 bits: origin sign extended plus counter
		sx = {origin_x_q[10], origin_x_q} + {2'b00, column_s1};
		sy = {origin_y_q[10], origin_y_q} + {2'b00, row_s1};
		on_screen = !sx[11] && (sx[10:0] < SCR_W) && !sy[11] && (sy[10:0] < SCR_H);

		// on screen, sy stays below 1023 so its low ten bits carry it
		row_base = 20'(sy[9:0]) * 20'(SCREEN_WIDTH);
		scr_sum  = row_base + 20'(sx[10:0]);

		alpha = src_s1[31:24];
		rgb   = tint_enable_q ? tint_rgb_q : src_s1[23:0];

		res_d.write_enable  = on_screen;
		res_d.screen_index  = on_screen ? scr_sum[18:0] : 19'd0;
		res_d.source_index  = src_base_q + 22'(column_s1) + row_offset_s1;
		res_d.blended_pixel = {mix_channel(rgb[23:16], dst_s1[23:16], alpha),
			mix_channel(rgb[15:8], dst_s1[15:8], alpha),
			mix_channel(rgb[7:0], dst_s1[7:0], alpha)};
		res_d.last          = last_s1;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (!stall && valid_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

// File: src/cab_checker.sv
// ----------------------------------------------------------------------------
// cab_checker
// port-level checks of the clipped alpha blit unit, bound to the top level
// ----------------------------------------------------------------------------
`include "clipped_alpha_blit_unit_assert.svh"

module cab_checker #(
	parameter int SCREEN_WIDTH  = cab_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = cab_pkg::SCREEN_HEIGHT_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_valid,
	input logic             pixel_ready,
	input logic             result_valid,
	input logic             result_ready,
	input cab_pkg::result_t result
);

	localparam logic [19:0] SCR_WORDS = 20'(SCREEN_WIDTH * SCREEN_HEIGHT);

	// a stalled result keeps its value
	`CAB_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// a free receiver never blocks requests
	`CAB_ASSERT_SAME(a_ready_when_drained, result_ready, pixel_ready)

	// an accepted request moves on to the result port when the receiver is ready to let it through
	`CAB_ASSERT_NEXT(a_latency, (pixel_valid && pixel_ready) ##1 result_ready, result_valid)

	// clipped positions carry index zero, written ones stay inside the screen
	`CAB_ASSERT_SAME(a_index_range, result_valid, (!result.write_enable && result.screen_index == 19'd0) || (result.write_enable && {1'b0, result.screen_index} < SCR_WORDS))

endmodule

bind clipped_alpha_blit_unit cab_checker #(
	.SCREEN_WIDTH (SCREEN_WIDTH),
	.SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_cab_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

// File: tb/blit_monitor.sv
// ----------------------------------------------------------------------------
// blit_monitor
// watches the pixel, result and cfg ports of the blit unit, models the
// blend, clip and index logic, and compares every result in order
// ----------------------------------------------------------------------------
module blit_monitor #(
	parameter int SCR_COLS = cab_pkg::SCREEN_WIDTH_DEF,
	parameter int SCR_ROWS = cab_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pixel_valid,
	input  logic                            pixel_ready,
	input  cab_pkg::pixel_t                 pixel,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  cab_pkg::result_t                result,
	input  logic                            cfg_write,
	input  logic [cab_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cab_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              outstanding
);

	// register copy
	logic signed [10:0] org_x, org_y;
	logic [9:0]         reg_w, reg_h;
	logic [21:0]        base_idx;
	logic [12:0]        stride;
	logic               tint_on;
	logic [23:0]        tint_col;

	// raster position
	logic [9:0]  col, row;
	logic [21:0] row_off;

	cab_pkg::result_t pending_blits[$];
	cab_pkg::result_t want, blit;

	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		int v;
		v = (int'(s) * int'(a) + int'(d) * (255 - int'(a))) / 256;
		return v[7:0];
	endfunction

	// result of one pixel at the current position, then step the raster
	task automatic predict_blit(input cab_pkg::pixel_t p, output cab_pkg::result_t r);
		int sx, sy, w, h, scr;
		logic on, row_end, fin;
		logic [7:0] a;
		logic [23:0] rgb;
		sx = int'(org_x) + int'(col);
		sy = int'(org_y) + int'(row);
		w = (reg_w == 0) ? 1 : int'(reg_w);
		h = (reg_h == 0) ? 1 : int'(reg_h);
		on = sx >= 0 && sx < SCR_COLS && sy >= 0 && sy < SCR_ROWS;
		scr = on ? sx + sy * SCR_COLS : 0;
		a = p.source_pixel[31:24];
		rgb = tint_on ? tint_col : p.source_pixel[23:0];
		row_end = int'(col) + 1 >= w;
		fin = row_end && (int'(row) + 1 >= h);
		r.write_enable = on;
		r.screen_index = scr[18:0];
		r.source_index = base_idx + 22'(col) + row_off;
		r.blended_pixel = {mix(rgb[23:16], p.dest_pixel[23:16], a),
			mix(rgb[15:8], p.dest_pixel[15:8], a), mix(rgb[7:0], p.dest_pixel[7:0], a)};
		r.last = fin;
		if (fin) begin
			col = '0;
			row = '0;
			row_off = '0;
		end else if (row_end) begin
			col = '0;
			row = row + 10'd1;
			row_off = row_off + 22'(stride);
		end else begin
			col = col + 10'd1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x = cab_pkg::ORIGIN_RST;
			org_y = cab_pkg::ORIGIN_RST;
			reg_w = cab_pkg::RECT_RST;
			reg_h = cab_pkg::RECT_RST;
			base_idx = cab_pkg::BASE_RST;
			stride = cab_pkg::STRIDE_RST;
			tint_on = 1'b0;
			tint_col = cab_pkg::TINT_RST;
			col = '0;
			row = '0;
			row_off = '0;
			pending_blits.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_blits.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, result);
					fail_count++;
				end else begin
					want = pending_blits.pop_front();
					check_field("write_enable", want.write_enable, result.write_enable);
					check_field("screen_index", want.screen_index, result.screen_index);
					check_field("source_index", want.source_index, result.source_index);
					check_field("blended_pixel", want.blended_pixel, result.blended_pixel);
					check_field("last", want.last, result.last);
				end
			end
			if (pixel_valid && pixel_ready) begin
				predict_blit(pixel, blit);
				pending_blits.push_back(blit);
			end
			if (cfg_write) begin
				case (cab_pkg::cfg_reg_t'(cfg_index))
					cab_pkg::REG_ORIGIN_X:       org_x = cfg_data[10:0];
					cab_pkg::REG_ORIGIN_Y:       org_y = cfg_data[10:0];
					cab_pkg::REG_RECT_W:         reg_w = cfg_data[9:0];
					cab_pkg::REG_RECT_H:         reg_h = cfg_data[9:0];
					cab_pkg::REG_SRC_BASE_INDEX: base_idx = cfg_data[21:0];
					cab_pkg::REG_SRC_STRIDE:     stride = cfg_data[12:0];
					cab_pkg::REG_TINT_ENABLE:    tint_on = cfg_data[0];
					cab_pkg::REG_TINT_RGB:       tint_col = cfg_data[23:0];
					default: ;
				endcase
			end
			outstanding = pending_blits.size();
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the clipped alpha blit unit with directed and random regions, with
// bursty requests and a stalling result side, and reports the verdict
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_ITEMS = 1300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int CFG_W        = cab_pkg::CFG_DATA_W;

	// result side stall patterns
	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC,
		RX_STARVED
	} rx_mode_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            pixel_valid = 1'b0;
	logic                            pixel_ready;
	cab_pkg::pixel_t                 pixel = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	cab_pkg::result_t                result;
	logic                            cfg_write = 1'b0;
	logic [cab_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]                cfg_data = '0;

	int fail_count, outstanding;
	int burst_left = 0;
	int idle_cycles = 0;
	int rx_left = 0;
	int rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int sent, items;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	clipped_alpha_blit_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	blit_monitor #(
		.SCR_COLS (cab_pkg::SCREEN_WIDTH_DEF),
		.SCR_ROWS (cab_pkg::SCREEN_HEIGHT_DEF)
	) blit_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// result side: each pattern holds for a random stretch
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 4));
			rx_left = $urandom_range(20, 200);
		end
		rx_left = rx_left - 1;
		rx_tick = rx_tick + 1;
		case (rx_mode)
			RX_OPEN:     result_ready <= 1'b1;
			RX_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE:   result_ready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: result_ready <= ((rx_tick % 7) < 4);
			default:     result_ready <= ((rx_tick % 24) == 0);
		endcase
	end

	// watchdog: too long without any handshake or register write
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready)
			|| cfg_write) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// random pixel, alpha often at its extremes
	function automatic cab_pkg::pixel_t rand_pixel();
		cab_pkg::pixel_t p;
		p.source_pixel = $urandom;
		p.dest_pixel = $urandom;
		case ($urandom_range(0, 3))
			0: p.source_pixel[31:24] = 8'h00;
			1: p.source_pixel[31:24] = 8'hFF;
			default: ;
		endcase
		return p;
	endfunction

	// one request; bursts of random length, random gaps between them
	task automatic send_pixel(input cab_pkg::pixel_t p);
		bit took;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left = burst_left - 1;
		pixel <= p;
		pixel_valid <= 1'b1;
		// ready is settled by the falling edge, so sample it there
		do begin
			@(negedge clk);
			took = pixel_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// stop sending and wait until every expected result has come back
	task automatic drain_results();
		pixel_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
		// margin past the pipeline latency
		repeat (3) @(posedge clk);
	endtask

	// idle the block, then write all eight registers back to back
	task automatic set_region(input logic [10:0] ox, input logic [10:0] oy,
		input logic [9:0] w, input logic [9:0] h, input logic [21:0] base,
		input logic [12:0] stride, input logic tint_en, input logic [23:0] tint);
		logic [CFG_W-1:0] vals [8];
		drain_results();
		vals[cab_pkg::REG_ORIGIN_X] = CFG_W'(ox);
		vals[cab_pkg::REG_ORIGIN_Y] = CFG_W'(oy);
		vals[cab_pkg::REG_RECT_W] = CFG_W'(w);
		vals[cab_pkg::REG_RECT_H] = CFG_W'(h);
		vals[cab_pkg::REG_SRC_BASE_INDEX] = CFG_W'(base);
		vals[cab_pkg::REG_SRC_STRIDE] = CFG_W'(stride);
		vals[cab_pkg::REG_TINT_ENABLE] = CFG_W'(tint_en);
		vals[cab_pkg::REG_TINT_RGB] = CFG_W'(tint);
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= cab_pkg::cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// random settings, mostly small regions near the screen edges
	task automatic random_region(output int count);
		logic [10:0] ox, oy;
		logic [9:0] w, h;
		logic [21:0] base;
		logic [12:0] stride;
		logic [23:0] tint;
		int area;
		case ($urandom_range(0, 5))
			0: ox = 11'h400;
			1: ox = 11'h3FF;
			2: ox = 11'($urandom);
			default: ox = 11'($urandom_range(0, 720) - 40);
		endcase
		case ($urandom_range(0, 5))
			0: oy = 11'h400;
			1: oy = 11'h3FF;
			2: oy = 11'($urandom);
			default: oy = 11'($urandom_range(0, 520) - 30);
		endcase
		case ($urandom_range(0, 7))
			0: w = 10'h3FF;
			1: w = 10'd0;
			default: w = 10'($urandom_range(1, 24));
		endcase
		case ($urandom_range(0, 7))
			0: h = 10'h3FF;
			1: h = 10'd0;
			default: h = 10'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 4))
			0: base = 22'h3FFFFF;
			1: base = 22'd0;
			default: base = 22'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: stride = 13'd0;
			1: stride = 13'd4096;
			2: stride = 13'h1FFF;
			default: stride = 13'($urandom_range(1, 700));
		endcase
		case ($urandom_range(0, 5))
			0: tint = 24'h000000;
			1: tint = 24'hFFFFFF;
			default: tint = 24'($urandom);
		endcase
		area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
		// whole regions where they are small, else a slice of one
		count = (area <= 250) ? area * $urandom_range(1, 3) : $urandom_range(60, 250);
		set_region(ox, oy, w, h, base, stride, 1'($urandom_range(0, 1)), tint);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a 1x1 region, every request is last
		send_pixel({32'h00000000, 32'h00000000});
		send_pixel({32'hFFFFFFFF, 32'hFFFFFFFF});

		// clipped on the top row and left column, source index wraps
		set_region(11'h7FF, 11'h7FF, 10'd3, 10'd2, 22'h3FFFFE, 13'h1FFF, 1'b0, 24'h0);
		send_pixel({32'h00FFFFFF, 32'hFF000000});
		send_pixel({32'hFF000000, 32'h00FFFFFF});
		send_pixel({32'h80FF00FF, 32'h0000FF00});
		repeat (3) send_pixel(rand_pixel());

		// bottom-right corner, zero stride, white tint
		set_region(11'd639, 11'd479, 10'd2, 10'd2, 22'd0, 13'd0, 1'b1, 24'hFFFFFF);
		send_pixel({32'hFF123456, 32'h00ABCDEF});
		send_pixel({32'h00123456, 32'h00ABCDEF});
		repeat (2) send_pixel(rand_pixel());

		// zero width and height act as one
		set_region(11'd0, 11'd0, 10'd0, 10'd0, 22'h3FFFFF, 13'd4096, 1'b1, 24'h000000);
		repeat (2) send_pixel(rand_pixel());

		// region shrunk part way through: counters already past the edge
		set_region(11'd100, 11'd50, 10'd5, 10'd5, 22'd7, 13'd3, 1'b0, 24'h0);
		repeat (7) send_pixel(rand_pixel());
		set_region(11'd100, 11'd50, 10'd1, 10'd1, 22'd7, 13'd3, 1'b0, 24'h0);
		send_pixel(rand_pixel());

		// random phases, each after a full drain and a new setting
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			random_region(items);
			// last phase only fills up to the item budget
			if (items > RANDOM_ITEMS - sent) begin
				items = RANDOM_ITEMS - sent;
			end
			repeat (items) send_pixel(rand_pixel());
			sent = sent + items;
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
